// File: rtl/bsr_pkg.sv
package bsr_pkg;

  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_LINE   = 3'd1;
  localparam logic [2:0] KIND_RECT   = 3'd2;
  localparam logic [2:0] KIND_CIRCLE = 3'd3;
  localparam logic [2:0] KIND_TRI    = 3'd4;
  localparam logic [2:0] KIND_READ   = 3'd5;

  localparam int FIELD_W = 6;
  localparam int WORD_W  = 64;

  typedef struct packed {
    logic [2:0]         kind;
    logic [FIELD_W-1:0] row_pos;
    logic [FIELD_W-1:0] col_pos;
    logic [FIELD_W-1:0] extent;
    logic [FIELD_W-1:0] second_extent;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] inner;
    logic [5:0] outer;
  } ring_t;

  function automatic logic [WORD_W-1:0] span_mask(input logic signed [8:0] lo,
                                                  input logic signed [8:0] hi);
    logic [WORD_W-1:0] m;
    logic signed [8:0] jj;
    m = '0;
    for (int j = 0; j < WORD_W; j++) begin
      jj = 9'(j);
      m[j] = (jj >= lo) && (jj <= hi);
    end
    return m;
  endfunction

endpackage

// File: rtl/bsr_isqrt.sv
module bsr_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [11:0] operand,
  output logic        done,
  output logic [5:0]  root
);

  logic [11:0] value;
  logic [2:0]  step;
  logic        run;
  logic [5:0]  cand;
  logic [11:0] prod;

  always_comb begin
    cand = root | (6'd1 << step);
    prod = 12'(cand) * 12'(cand);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
      root <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        value <= operand;
        root  <= '0;
        step  <= 3'd5;
        run   <= 1'b1;
      end else if (run) begin
        if (prod <= value) begin
          root <= cand;
        end
        if (step == 3'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 3'd1;
        end
      end
    end
  end

endmodule

// File: rtl/bsr_row_mask.sv
module bsr_row_mask #(
  parameter int CANVAS_COLS = 64
) (
  input  bsr_pkg::cmd_t  cmd,
  input  logic [5:0]     row,
  input  bsr_pkg::ring_t ring,
  output logic [63:0]    mask
);

  localparam logic [63:0] COL_MASK =
    (CANVAS_COLS >= 64) ? '1 : ((64'd1 << CANVAS_COLS) - 64'd1);

  logic [7:0]        r8, c8, n8, h8, i8;
  logic [7:0]        c_end, bot_rect, bot_tri, diag;
  logic signed [8:0] ctr, outer9, inner9;
  logic [63:0]       shape;

  always_comb begin
    r8       = {2'b0, cmd.row_pos};
    c8       = {2'b0, cmd.col_pos};
    n8       = {2'b0, cmd.extent};
    h8       = {2'b0, cmd.second_extent};
    i8       = {2'b0, row};
    c_end    = c8 + n8 - 8'd1;
    bot_rect = r8 + h8 - 8'd1;
    bot_tri  = r8 + n8 - 8'd1;
    diag     = c8 + (i8 - r8);
    ctr      = $signed({3'b0, cmd.col_pos});
    outer9   = $signed({3'b0, ring.outer});
    inner9   = $signed({2'b0, ring.inner});
    shape    = '0;
    case (cmd.kind)
      bsr_pkg::KIND_LINE: begin
        if (n8 != 8'd0 && i8 == r8) begin
          shape = bsr_pkg::span_mask($signed({1'b0, c8}), $signed({1'b0, c_end}));
        end
      end
      bsr_pkg::KIND_RECT: begin
        if (n8 != 8'd0 && h8 != 8'd0) begin
          if (i8 == r8 || i8 == bot_rect) begin
            shape = bsr_pkg::span_mask($signed({1'b0, c8}), $signed({1'b0, c_end}));
          end else if (i8 > r8 && i8 < bot_rect) begin
            shape = bsr_pkg::span_mask($signed({1'b0, c8}), $signed({1'b0, c8}))
                  | bsr_pkg::span_mask($signed({1'b0, c_end}), $signed({1'b0, c_end}));
          end
        end
      end
      bsr_pkg::KIND_TRI: begin
        if (n8 != 8'd0 && i8 >= r8 && i8 <= bot_tri) begin
          shape = bsr_pkg::span_mask($signed({1'b0, c8}), $signed({1'b0, c8}))
                | bsr_pkg::span_mask($signed({1'b0, diag}), $signed({1'b0, diag}));
          if (i8 == bot_tri) begin
            shape = shape
                  | bsr_pkg::span_mask($signed({1'b0, c8}), $signed({1'b0, c_end}));
          end
        end
      end
      bsr_pkg::KIND_CIRCLE: begin
        if (ring.hit) begin
          shape = bsr_pkg::span_mask(ctr - outer9, ctr - inner9)
                | bsr_pkg::span_mask(ctr + inner9, ctr + outer9);
        end
      end
      default: begin
        shape = '0;
      end
    endcase
    mask = shape & COL_MASK;
  end

endmodule

// File: rtl/bitmap_shape_rasterizer_unit.sv
// Channel   Handshake         Ports
// command   start, busy       kind, row_pos, col_pos, extent, second_extent
// result    done (one cycle)  row_bits, was_read
//
// Clear, unused kinds and a read beyond the canvas finish straight from idle; a row read
// within the canvas passes through a read wait state. Line, rectangle and triangle sweep
// every canvas row: one canvas row is read, merged and written back per cycle through the
// canvas read and write ports. A circle is drawn row by row with the shared square root
// unit, which yields one result bit per cycle and runs up to twice per row.
// Reset clears the canvas at once through per-row valid bits; results cannot be stalled.
module bitmap_shape_rasterizer_unit #(
  parameter int CANVAS_ROWS = 32,
  parameter int CANVAS_COLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [5:0]  row_pos,
  input  logic [5:0]  col_pos,
  input  logic [5:0]  extent,
  input  logic [5:0]  second_extent,
  output logic        done,
  output logic [63:0] row_bits,
  output logic        was_read
);

  localparam int ROW_W = $clog2(CANVAS_ROWS);
  localparam int CNT_W = $clog2(CANVAS_ROWS + 1);
  localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(CANVAS_ROWS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_CIR_SETUP,
    S_CIR_ROW,
    S_CIR_HI,
    S_CIR_HI_WAIT,
    S_CIR_LO_WAIT,
    S_CIR_WRITE,
    S_READ_WAIT
  } state_t;

  state_t           state;
  bsr_pkg::cmd_t    cmd;
  bsr_pkg::ring_t   ring;
  logic [CNT_W-1:0] row;
  logic [ROW_W-1:0] wr_row;
  logic             wr_pend;
  logic [63:0]      mask_q;
  logic [11:0]      nsq;
  logic [11:0]      dr2;

  logic [63:0]      mem [CANVAS_ROWS];
  logic [CANVAS_ROWS-1:0] valid;
  logic [63:0]      mem_q;
  logic             qv;

  logic             rd_en, wr_en, in_range;
  logic [ROW_W-1:0] rd_addr, wr_addr;
  logic [63:0]      rdata, wr_data, mask_out;
  logic [5:0]       row6, sq_in, dr_abs;
  logic signed [7:0]  dr;
  logic [11:0]      sq_out;
  logic signed [13:0] t_hi, t_lo1;
  logic             sq_start, sq_done;
  logic [5:0]       sq_root;
  logic [11:0]      sq_operand;

  bsr_row_mask #(
    .CANVAS_COLS(CANVAS_COLS)
  ) u_mask (
    .cmd  (cmd),
    .row  (row6),
    .ring (ring),
    .mask (mask_out)
  );

  bsr_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (sq_operand),
    .done    (sq_done),
    .root    (sq_root)
  );

  always_comb begin
    busy     = (state != S_IDLE);
    row6     = 6'(row);
    in_range = {1'b0, row_pos} < 7'(CANVAS_ROWS);
    dr       = $signed({2'b0, row6}) - $signed({2'b0, cmd.row_pos});
    dr_abs   = dr[7] ? 6'(-dr) : 6'(dr);
    sq_in    = (state == S_CIR_SETUP) ? cmd.extent : dr_abs;
    sq_out   = 12'(sq_in) * 12'(sq_in);
    t_hi     = $signed({2'b0, nsq}) + $signed(14'(cmd.extent)) - $signed({2'b0, dr2});
    t_lo1    = $signed({2'b0, nsq}) - $signed(14'(cmd.extent)) - $signed({2'b0, dr2})
             - 14'sd1;
    sq_start = (state == S_CIR_HI && !t_hi[13])
            || (state == S_CIR_HI_WAIT && sq_done && !t_lo1[13]);
    sq_operand = (state == S_CIR_HI) ? t_hi[11:0] : t_lo1[11:0];

    rd_en   = (state == S_IDLE && start && kind == bsr_pkg::KIND_READ && in_range)
           || state == S_SWEEP || state == S_CIR_ROW;
    rd_addr = (state == S_IDLE) ? row_pos[ROW_W-1:0] : row[ROW_W-1:0];
    rdata   = qv ? mem_q : '0;
    wr_en   = wr_pend || state == S_CIR_WRITE;
    wr_addr = (state == S_CIR_WRITE) ? row[ROW_W-1:0] : wr_row;
    wr_data = rdata | ((state == S_CIR_WRITE) ? mask_out : mask_q);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      qv    <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      was_read <= 1'b0;
      row_bits <= '0;
      valid    <= '0;
      wr_pend  <= 1'b0;
      row      <= '0;
    end else begin
      done     <= 1'b0;
      was_read <= 1'b0;
      row_bits <= '0;
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd <= '{kind: kind, row_pos: row_pos, col_pos: col_pos,
                     extent: extent, second_extent: second_extent};
            row <= '0;
            case (kind)
              bsr_pkg::KIND_CLEAR: begin
                valid <= '0;
                done  <= 1'b1;
              end
              bsr_pkg::KIND_LINE, bsr_pkg::KIND_RECT, bsr_pkg::KIND_TRI: begin
                state <= S_SWEEP;
              end
              bsr_pkg::KIND_CIRCLE: begin
                state <= S_CIR_SETUP;
              end
              bsr_pkg::KIND_READ: begin
                if (in_range) begin
                  state <= S_READ_WAIT;
                end else begin
                  done     <= 1'b1;
                  was_read <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SWEEP: begin
          mask_q  <= mask_out;
          wr_row  <= row[ROW_W-1:0];
          wr_pend <= 1'b1;
          if (row == LAST_ROW) begin
            state <= S_DRAIN;
          end else begin
            row <= row + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          wr_pend <= 1'b0;
          done    <= 1'b1;
          state   <= S_IDLE;
        end
        S_CIR_SETUP: begin
          nsq   <= sq_out;
          state <= S_CIR_ROW;
        end
        S_CIR_ROW: begin
          dr2   <= sq_out;
          state <= S_CIR_HI;
        end
        S_CIR_HI: begin
          if (t_hi[13]) begin
            ring.hit <= 1'b0;
            state    <= S_CIR_WRITE;
          end else begin
            state <= S_CIR_HI_WAIT;
          end
        end
        S_CIR_HI_WAIT: begin
          if (sq_done) begin
            ring.hit   <= 1'b1;
            ring.outer <= sq_root;
            if (t_lo1[13]) begin
              ring.inner <= '0;
              state      <= S_CIR_WRITE;
            end else begin
              state <= S_CIR_LO_WAIT;
            end
          end
        end
        S_CIR_LO_WAIT: begin
          if (sq_done) begin
            ring.inner <= {1'b0, sq_root} + 7'd1;
            state      <= S_CIR_WRITE;
          end
        end
        S_CIR_WRITE: begin
          if (row == LAST_ROW) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            row   <= row + CNT_W'(1);
            state <= S_CIR_ROW;
          end
        end
        S_READ_WAIT: begin
          done     <= 1'b1;
          was_read <= 1'b1;
          row_bits <= rdata;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/bsr_checker.sv
module bsr_checker #(
  parameter int CANVAS_ROWS = 32,
  parameter int CANVAS_COLS = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [2:0]  kind,
  input logic [5:0]  row_pos,
  input logic        done,
  input logic [63:0] row_bits,
  input logic        was_read
);

  logic accept;
  assign accept = start && !busy;

  a_quiet_between: assert property (@(posedge clk) disable iff (rst)
    !done |-> (row_bits == 64'd0 && !was_read))
    else $error("result ports not quiet outside a result cycle");

  a_clear_fast: assert property (@(posedge clk) disable iff (rst)
    accept && kind == bsr_pkg::KIND_CLEAR |=> done && !was_read && !busy)
    else $error("clear item did not finish in one cycle");

  a_read_outside: assert property (@(posedge clk) disable iff (rst)
    accept && kind == bsr_pkg::KIND_READ && {1'b0, row_pos} >= 7'(CANVAS_ROWS)
    |=> done && was_read && row_bits == 64'd0)
    else $error("read beyond the canvas gave a wrong result");

  a_shape_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (kind == bsr_pkg::KIND_LINE || kind == bsr_pkg::KIND_RECT ||
               kind == bsr_pkg::KIND_TRI || kind == bsr_pkg::KIND_CIRCLE)
    |=> busy && !done)
    else $error("shape item finished too early");

  a_cols_clipped: assert property (@(posedge clk) disable iff (rst)
    done && was_read |-> (row_bits >> CANVAS_COLS) == 64'd0)
    else $error("read row shows cells beyond the canvas width");

endmodule

bind bitmap_shape_rasterizer_unit bsr_checker #(
  .CANVAS_ROWS(CANVAS_ROWS),
  .CANVAS_COLS(CANVAS_COLS)
) u_bsr_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .kind     (kind),
  .row_pos  (row_pos),
  .done     (done),
  .row_bits (row_bits),
  .was_read (was_read)
);

// File: tb/sv/bitmap_shape_rasterizer_unit_tb.sv
module bitmap_shape_rasterizer_unit_tb;

  localparam int ROWS = 32;
  localparam int COLS = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 350;
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct {
    bsr_pkg::cmd_t cmd;
    int   idle_pct;
    bit   drain;
  } queued_cmd_t;

  typedef struct packed {
    logic [63:0] bits;
    logic        was_read;
  } row_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  kind = '0;
  logic [5:0]  row_pos = '0;
  logic [5:0]  col_pos = '0;
  logic [5:0]  extent = '0;
  logic [5:0]  second_extent = '0;
  logic        done;
  logic [63:0] row_bits;
  logic        was_read;

  queued_cmd_t cmd_backlog[$];
  row_result_t results_due[$];
  logic [63:0] shadow_canvas [ROWS];
  int          results_owed = 0;
  int          idle_cycles = 0;
  int          mismatches = 0;

  bitmap_shape_rasterizer_unit #(
    .CANVAS_ROWS(ROWS),
    .CANVAS_COLS(COLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .row_pos(row_pos),
    .col_pos(col_pos),
    .extent(extent),
    .second_extent(second_extent),
    .done(done),
    .row_bits(row_bits),
    .was_read(was_read)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void paint_cell(int r, int c);
    if (r >= 0 && c >= 0 && r < ROWS && c < COLS) begin
      shadow_canvas[r][c] = 1'b1;
    end
  endfunction

  function automatic row_result_t rasterize(bsr_pkg::cmd_t cmd);
    row_result_t res;
    int r, c, n, h, lo, hi, d;
    res = '0;
    r = cmd.row_pos;
    c = cmd.col_pos;
    n = cmd.extent;
    h = cmd.second_extent;
    case (cmd.kind)
      bsr_pkg::KIND_CLEAR: begin
        for (int i = 0; i < ROWS; i++) shadow_canvas[i] = '0;
      end
      bsr_pkg::KIND_LINE: begin
        for (int i = 0; i < n; i++) paint_cell(r, c + i);
      end
      bsr_pkg::KIND_RECT: begin
        if (n > 0 && h > 0) begin
          for (int i = 0; i < n; i++) begin
            paint_cell(r, c + i);
            paint_cell(r + h - 1, c + i);
          end
          for (int i = 0; i < h; i++) begin
            paint_cell(r + i, c);
            paint_cell(r + i, c + n - 1);
          end
        end
      end
      bsr_pkg::KIND_CIRCLE: begin
        lo = n * n - n;
        hi = n * n + n;
        for (int i = 0; i < ROWS; i++) begin
          for (int j = 0; j < COLS; j++) begin
            d = (i - r) * (i - r) + (j - c) * (j - c);
            if (d >= lo && d <= hi) paint_cell(i, j);
          end
        end
      end
      bsr_pkg::KIND_TRI: begin
        for (int i = 0; i < n; i++) begin
          paint_cell(r + i, c);
          paint_cell(r + n - 1, c + i);
          paint_cell(r + i, c + i);
        end
      end
      bsr_pkg::KIND_READ: begin
        res.was_read = 1'b1;
        if (r < ROWS) res.bits = shadow_canvas[r];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic int pick_size();
    return ($urandom_range(99) < 80) ? $urandom_range(12) : $urandom_range(63);
  endfunction

  function automatic bsr_pkg::cmd_t random_cmd();
    bsr_pkg::cmd_t cmd;
    int w;
    w = $urandom_range(99);
    if (w < 3) cmd.kind = bsr_pkg::KIND_CLEAR;
    else if (w < 18) cmd.kind = bsr_pkg::KIND_LINE;
    else if (w < 33) cmd.kind = bsr_pkg::KIND_RECT;
    else if (w < 43) cmd.kind = bsr_pkg::KIND_CIRCLE;
    else if (w < 58) cmd.kind = bsr_pkg::KIND_TRI;
    else if (w < 96) cmd.kind = bsr_pkg::KIND_READ;
    else if (w < 98) cmd.kind = KIND_SPARE_LO;
    else cmd.kind = KIND_SPARE_HI;
    cmd.row_pos = ($urandom_range(99) < 85) ? 6'($urandom_range(31))
                                            : 6'($urandom_range(63));
    cmd.col_pos = 6'($urandom_range(63));
    cmd.extent = 6'(pick_size());
    cmd.second_extent = 6'(pick_size());
    return cmd;
  endfunction

  function automatic void queue_cmd(logic [2:0] k, int r, int c, int n, int h,
                                    int idle_pct, bit drain);
    queued_cmd_t item;
    item.cmd.kind = k;
    item.cmd.row_pos = 6'(r);
    item.cmd.col_pos = 6'(c);
    item.cmd.extent = 6'(n);
    item.cmd.second_extent = 6'(h);
    item.idle_pct = idle_pct;
    item.drain = drain;
    cmd_backlog.push_back(item);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) void'(cmd_backlog.pop_front());
      if (cmd_backlog.size() != 0 &&
          (!cmd_backlog[0].drain || (!start && results_owed == 0)) &&
          $urandom_range(99) >= cmd_backlog[0].idle_pct) begin
        start <= 1'b1;
        kind <= cmd_backlog[0].cmd.kind;
        row_pos <= cmd_backlog[0].cmd.row_pos;
        col_pos <= cmd_backlog[0].cmd.col_pos;
        extent <= cmd_backlog[0].cmd.extent;
        second_extent <= cmd_backlog[0].cmd.second_extent;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    row_result_t want;
    bsr_pkg::cmd_t cmd;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        cmd.kind = kind;
        cmd.row_pos = row_pos;
        cmd.col_pos = col_pos;
        cmd.extent = extent;
        cmd.second_extent = second_extent;
        results_due.push_back(rasterize(cmd));
        moved = 1'b1;
      end
      if (done) begin
        moved = 1'b1;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result row_bits %h was_read %b",
                   $time, row_bits, was_read);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (row_bits !== want.bits) begin
            $display("%0t: row_bits expected %h actual %h", $time, want.bits, row_bits);
            mismatches++;
          end
          if (was_read !== want.was_read) begin
            $display("%0t: was_read expected %b actual %b",
                     $time, want.was_read, was_read);
            mismatches++;
          end
        end
      end
    end
    results_owed <= results_due.size();
    idle_cycles <= moved ? 0 : idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int idle_by_phase[4];
    idle_by_phase = '{0, 63, 0, 26};
    for (int i = 0; i < ROWS; i++) shadow_canvas[i] = '0;

    queue_cmd(bsr_pkg::KIND_READ, 0, 0, 0, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_LINE, 0, 0, 63, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_LINE, 31, 63, 1, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_LINE, 5, 10, 0, 63, 0, 0);
    queue_cmd(bsr_pkg::KIND_READ, 0, 0, 0, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_READ, 31, 0, 0, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_RECT, 3, 3, 0, 5, 0, 0);
    queue_cmd(bsr_pkg::KIND_RECT, 3, 3, 5, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_RECT, 20, 60, 10, 20, 0, 0);
    queue_cmd(bsr_pkg::KIND_READ, 20, 0, 0, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_CLEAR, 63, 63, 63, 63, 0, 0);
    queue_cmd(bsr_pkg::KIND_CIRCLE, 10, 30, 0, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_CIRCLE, 63, 63, 0, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_READ, 10, 0, 0, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_CIRCLE, 16, 32, 63, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_CIRCLE, 63, 63, 40, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_READ, 16, 0, 0, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_TRI, 0, 0, 0, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_TRI, 20, 50, 63, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_READ, 25, 0, 0, 0, 0, 0);
    queue_cmd(KIND_SPARE_LO, 1, 2, 3, 4, 0, 0);
    queue_cmd(KIND_SPARE_HI, 63, 63, 63, 63, 0, 0);
    queue_cmd(bsr_pkg::KIND_READ, 32, 0, 0, 0, 0, 0);
    queue_cmd(bsr_pkg::KIND_READ, 63, 63, 63, 63, 0, 0);
    queue_cmd(bsr_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0);

    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        queued_cmd_t item;
        item.cmd = random_cmd();
        item.idle_pct = idle_by_phase[p];
        item.drain = (i == 0);
        cmd_backlog.push_back(item);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || start || results_owed != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
